FILE: design/matinv_pkg.sv
// Shared types and index helpers for the 4x4 matrix inverse block.
// No dependencies; imported by matinv_div, matrix4x4_inverse_top and the testbench.
package matinv_pkg;

    // Sequencer states of the top level
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_TERM_A,
        ST_MUL_A,
        ST_TERM_B,
        ST_MUL_B,
        ST_DET_SET,
        ST_DET_MUL,
        ST_CHECK,
        ST_DIV_SET,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    // n-th index (0..2) of 0..3 with one index left out
    function automatic logic [1:0] minor_idx(input logic [1:0] n, input logic [1:0] skip);
        logic [1:0] r;
        r = (n >= skip) ? n + 2'd1 : n;
        return r;
    endfunction

    // Column of row pos in permutation t of a 3x3 determinant
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] pos);
        logic [5:0] p;
        unique case (t)
            3'd0: p = {2'd2, 2'd1, 2'd0};
            3'd1: p = {2'd1, 2'd2, 2'd0};
            3'd2: p = {2'd2, 2'd0, 2'd1};
            3'd3: p = {2'd0, 2'd2, 2'd1};
            3'd4: p = {2'd1, 2'd0, 2'd2};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        unique case (pos)
            2'd0: return p[1:0];
            2'd1: return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    // Odd permutations carry a minus sign
    function automatic logic perm_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

FILE: design/matrix4x4_inverse_top.sv
// Top level of the 4x4 fixed-point matrix inverse (cofactor and adjugate).
// Depends on matinv_pkg and matinv_div.

// Sixteen signed elements are loaded in row-major order, one beat per cycle
// while in_valid is high; in_ready is high only while loading. After the sixteenth,
// one shared shift-add multiplier builds the sixteen exact cofactors (twelve
// products each) and the determinant (four more), each product prepared in a
// setup state before its shift-add steps; then a bit-serial divider forms each element as
// cofactor * 2^(2*FRAC_BITS) / det in 3*DATA_WIDTH+3+2*FRAC_BITS steps, and each
// result then holds until out_ready takes it. The sixteen results leave in
// row-major order from an output register; with a zero determinant all are
// zero, singular is set, and no division runs.
module matrix4x4_inverse_top
    import matinv_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] element_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] inverse_value,
    output logic [3:0]                   element_index,
    output logic                         last_element,
    output logic                         singular
);

    localparam int COFW = 3 * DATA_WIDTH + 3;
    localparam int ACCW = 4 * DATA_WIDTH + 5;
    localparam int NUMW = COFW + 2 * FRAC_BITS;
    localparam int MW   = $clog2(DATA_WIDTH);

    state_t state_reg, state_next;

    logic signed [DATA_WIDTH-1:0] elem_mem [16];
    logic signed [COFW-1:0]       cof_mem  [16];

    logic [3:0]             load_reg;
    logic [3:0]             k_reg;
    logic [2:0]             t_reg;
    logic [MW-1:0]          bit_reg;
    logic signed [ACCW-1:0] x_reg;
    logic [DATA_WIDTH-1:0]  y_reg;
    logic signed [ACCW-1:0] prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] det_reg;
    logic                   sing_reg;
    logic signed [DATA_WIDTH-1:0] out_val_reg;

    logic                   in_beat;
    logic                   out_beat;
    logic                   mul_last;
    logic signed [ACCW-1:0] mul_sum;
    logic signed [ACCW-1:0] term_acc;
    logic [1:0]             row_a, row_b, row_c;
    logic [3:0]             rd_addr;
    logic signed [DATA_WIDTH-1:0] rd_elem;
    logic signed [COFW-1:0] div_cof;
    logic [COFW-1:0]        cof_abs;
    logic [ACCW-1:0]        det_abs;
    logic                   div_start;
    logic                   div_done;
    logic signed [DATA_WIDTH-1:0] div_q;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;
    assign mul_last = bit_reg == MW'(DATA_WIDTH - 1);

    // minor rows for cofactor k
    assign row_a = minor_idx(2'd0, k_reg[3:2]);
    assign row_b = minor_idx(2'd1, k_reg[3:2]);
    assign row_c = minor_idx(2'd2, k_reg[3:2]);

    // element read address
    always_comb
    begin
        unique case (state_reg)
            ST_TERM_A: rd_addr = {row_b, minor_idx(perm_col(t_reg, 2'd1), k_reg[1:0])};
            ST_TERM_B: rd_addr = {row_c, minor_idx(perm_col(t_reg, 2'd2), k_reg[1:0])};
            ST_DET_SET: rd_addr = {2'd0, k_reg[1:0]};
            default: rd_addr = {row_a, minor_idx(perm_col(t_reg, 2'd0), k_reg[1:0])};
        endcase
    end
    assign rd_elem = elem_mem[rd_addr];

    // shift-add step: last multiplier bit has negative weight
    always_comb
    begin
        if (!y_reg[0])
            mul_sum = prod_reg;
        else if (mul_last)
            mul_sum = prod_reg - x_reg;
        else
            mul_sum = prod_reg + x_reg;
    end

    // signed accumulation of one permutation term
    assign term_acc = (perm_neg(t_reg) ^ k_reg[2] ^ k_reg[0]) ? acc_reg - mul_sum
                                                              : acc_reg + mul_sum;

    // divider operands: inverse (i,j) uses cofactor (j,i)
    assign div_cof   = cof_mem[{k_reg[1:0], k_reg[3:2]}];
    assign cof_abs   = div_cof[COFW-1] ? COFW'(-div_cof) : COFW'(div_cof);
    assign det_abs   = det_reg[ACCW-1] ? ACCW'(-det_reg) : ACCW'(det_reg);
    assign div_start = (state_reg == ST_DIV_SET) && !sing_reg;

    matinv_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .NUM_WIDTH  (NUMW),
        .DEN_WIDTH  (ACCW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_mag  (NUMW'(cof_abs) << (2 * FRAC_BITS)),
        .den_mag  (det_abs),
        .negative (div_cof[COFW-1] ^ det_reg[ACCW-1]),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:     if (in_beat && load_reg == 4'd15) state_next = ST_TERM_A;
            ST_TERM_A:   state_next = ST_MUL_A;
            ST_MUL_A:    if (mul_last) state_next = ST_TERM_B;
            ST_TERM_B:   state_next = ST_MUL_B;
            ST_MUL_B:
                if (mul_last)
                    state_next = (t_reg == 3'd5 && k_reg == 4'd15) ? ST_DET_SET : ST_TERM_A;
            ST_DET_SET:  state_next = ST_DET_MUL;
            ST_DET_MUL:
                if (mul_last)
                    state_next = (k_reg == 4'd3) ? ST_CHECK : ST_DET_SET;
            ST_CHECK:    state_next = ST_DIV_SET;
            ST_DIV_SET:  state_next = sing_reg ? ST_OUT : ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:
                if (out_beat)
                    state_next = (k_reg == 4'd15) ? ST_LOAD : ST_DIV_SET;
            default:     state_next = ST_LOAD;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = state_reg == ST_LOAD;
        out_valid = state_reg == ST_OUT;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            load_reg  <= '0;
            k_reg     <= '0;
            t_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_LOAD:
                    if (in_beat)
                    begin
                        load_reg <= load_reg + 4'd1;
                        k_reg    <= '0;
                        t_reg    <= '0;
                    end
                ST_TERM_A, ST_TERM_B, ST_DET_SET: bit_reg <= '0;
                ST_MUL_A: bit_reg <= bit_reg + 1'b1;
                ST_MUL_B:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (mul_last)
                    begin
                        t_reg <= (t_reg == 3'd5) ? 3'd0 : t_reg + 3'd1;
                        if (t_reg == 3'd5)
                            k_reg <= k_reg + 4'd1;
                    end
                end
                ST_DET_MUL:
                begin
                    bit_reg <= bit_reg + 1'b1;
                    if (mul_last)
                        k_reg <= (k_reg == 4'd3) ? 4'd0 : k_reg + 4'd1;
                end
                ST_OUT: if (out_beat) k_reg <= k_reg + 4'd1;
                default: ;
            endcase
        end
    end

    // datapath and stores
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:
                if (in_beat)
                begin
                    elem_mem[load_reg] <= element_value;
                    acc_reg <= '0;
                    det_reg <= '0;
                end
            ST_TERM_A:
            begin
                x_reg    <= ACCW'(elem_mem[{row_a, minor_idx(perm_col(t_reg, 2'd0),
                                                             k_reg[1:0])}]);
                y_reg    <= rd_elem;
                prod_reg <= '0;
            end
            ST_TERM_B:
            begin
                x_reg    <= prod_reg;
                y_reg    <= rd_elem;
                prod_reg <= '0;
            end
            ST_MUL_A, ST_MUL_B, ST_DET_MUL:
            begin
                prod_reg <= mul_sum;
                x_reg    <= x_reg <<< 1;
                y_reg    <= y_reg >> 1;
                if (mul_last && state_reg == ST_MUL_B)
                begin
                    if (t_reg == 3'd5)
                    begin
                        cof_mem[k_reg] <= COFW'(term_acc);
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= term_acc;
                end
                if (mul_last && state_reg == ST_DET_MUL)
                    det_reg <= det_reg + mul_sum;
            end
            ST_DET_SET:
            begin
                x_reg    <= ACCW'(cof_mem[{2'd0, k_reg[1:0]}]);
                y_reg    <= rd_elem;
                prod_reg <= '0;
            end
            ST_CHECK: sing_reg <= det_reg == '0;
            ST_DIV_SET: if (sing_reg) out_val_reg <= '0;
            ST_DIV_WAIT: if (div_done) out_val_reg <= div_q;
            default: ;
        endcase
    end

    assign inverse_value = out_val_reg;
    assign element_index = k_reg;
    assign last_element  = k_reg == 4'd15;
    assign singular      = sing_reg;

endmodule

FILE: design/matinv_div.sv
// Bit-serial restoring divider with signed saturation of the quotient.
// Depends on matinv_pkg; instantiated by matrix4x4_inverse_top.
module matinv_div
    import matinv_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_WIDTH  = 131,
    parameter int DEN_WIDTH  = 133
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_WIDTH-1:0]         num_mag,
    input  logic [DEN_WIDTH-1:0]         den_mag,
    input  logic                         negative,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quotient
);

    localparam int CW = $clog2(NUM_WIDTH);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [NUM_WIDTH-1:0]  num_reg;
    logic [DEN_WIDTH-1:0]  den_reg;
    logic [DEN_WIDTH-1:0]  rem_reg;
    logic [DATA_WIDTH:0]   q_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic [DEN_WIDTH:0]    rem_sh;
    logic                  ge;
    logic [DEN_WIDTH:0]    rem_sub;

    // one quotient bit per cycle
    assign rem_sh  = {rem_reg, num_reg[NUM_WIDTH-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_mag;
            den_reg <= den_mag;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= negative;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? rem_sub[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
            q_reg   <= {q_reg[DATA_WIDTH-1:0], ge};
            ovf_reg <= ovf_reg | q_reg[DATA_WIDTH];
        end
    end

    // saturate to the signed output range
    always_comb
    begin
        logic big_q;
        logic [DATA_WIDTH-1:0] low_q;
        big_q = ovf_reg | q_reg[DATA_WIDTH];
        low_q = q_reg[DATA_WIDTH-1:0];
        priority if (!neg_reg && (big_q || low_q[DATA_WIDTH-1]))
            quotient = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else if (neg_reg && (big_q || (low_q[DATA_WIDTH-1] && (low_q[DATA_WIDTH-2:0] != '0))))
            quotient = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else if (neg_reg)
            quotient = -low_q;
        else
            quotient = low_q;
    end

    assign done = done_reg;

endmodule

FILE: verif/tb_matrix4x4_inverse_top.sv
// Self-checking testbench for matrix4x4_inverse_top. Every inverse beat is checked: the
// directed matrix against fixed values, random ones against an exact cofactor/adjugate
// predictor in wide signed integers. Depends on matinv_pkg and matrix4x4_inverse_top.
module tb_matrix4x4_inverse_top;
    timeunit 1ns;
    timeprecision 1ps;
    import matinv_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int RANDOM_MATRICES = 23;
    localparam logic signed [DW-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [DW-1:0] VMIN = 32'sh80000000;

    typedef logic signed [255:0] wide_t;
    typedef struct packed {
        logic signed [DW-1:0] value;
        logic [3:0]           index;
        logic                 last;
        logic                 sing;
    } inv_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [DW-1:0] element_value;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [DW-1:0] inverse_value;
    logic [3:0]           element_index;
    logic                 last_element;
    logic                 singular;

    matrix4x4_inverse_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

    // Predictor state: loaded elements and fill position
    logic signed [DW-1:0] elem_store [16];
    logic [3:0]           fill_pos;
    bit                   predict_on;
    bit                   calm;
    inv_beat_t            inverse_queue [$];
    int                   mismatches;
    int                   beats_seen;
    int                   singular_seen;
    int                   saturated_seen;
    logic signed [DW-1:0] directed_rows [16];

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic wide_t el(input int r, input int c);
        return wide_t'(elem_store[r*4 + c]);
    endfunction

    // Signed cofactor of (r,c) from the 3x3 minor
    function automatic wide_t cofactor_of(input int r, input int c);
        int    rr [3];
        int    cc [3];
        int    n;
        wide_t m;
        n = 0;
        for (int i = 0; i < 4; i++) if (i != r) begin rr[n] = i; n++; end
        n = 0;
        for (int i = 0; i < 4; i++) if (i != c) begin cc[n] = i; n++; end
        m = el(rr[0], cc[0]) * (el(rr[1], cc[1]) * el(rr[2], cc[2])
                              - el(rr[1], cc[2]) * el(rr[2], cc[1]))
          - el(rr[0], cc[1]) * (el(rr[1], cc[0]) * el(rr[2], cc[2])
                              - el(rr[1], cc[2]) * el(rr[2], cc[0]))
          + el(rr[0], cc[2]) * (el(rr[1], cc[0]) * el(rr[2], cc[1])
                              - el(rr[1], cc[1]) * el(rr[2], cc[0]));
        return ((r + c) % 2 == 1) ? -m : m;
    endfunction

    // Full matrix done: push the sixteen inverse beats
    task automatic predict_inverse();
        wide_t     cof [16];
        wide_t     det;
        wide_t     q;
        inv_beat_t b;
        det = '0;
        for (int k = 0; k < 16; k++) cof[k] = cofactor_of(k / 4, k % 4);
        for (int c = 0; c < 4; c++) det = det + el(0, c) * cof[c];
        for (int k = 0; k < 16; k++) begin
            b.index = k[3:0];
            b.last  = (k == 15);
            b.sing  = (det == 0);
            b.value = '0;
            if (det != 0) begin
                q = (cof[(k % 4) * 4 + k / 4] <<< (2 * FB)) / det;
                if (q > wide_t'(VMAX)) b.value = VMAX;
                else if (q < wide_t'(VMIN)) b.value = VMIN;
                else b.value = q[DW-1:0];
            end
            inverse_queue.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH %s beat %0d: got %0d want %0d", what, beats_seen, got, want);
    endtask

    // Input and output monitors, sampled at the rising edge
    always @(posedge clk) begin
        inv_beat_t w;
        if (rst_n && in_valid && in_ready) begin
            elem_store[fill_pos] = element_value;
            if (fill_pos == 4'd15 && predict_on) predict_inverse();
            fill_pos = fill_pos + 4'd1;
        end
        if (rst_n && out_valid && out_ready) begin
            if (inverse_queue.size() == 0) begin
                report_mismatch("unexpected", inverse_value, 0);
            end else begin
                w = inverse_queue.pop_front();
                if (inverse_value !== w.value) report_mismatch("value", inverse_value, w.value);
                if (element_index !== w.index) report_mismatch("index", element_index, w.index);
                if (last_element !== w.last) report_mismatch("last", last_element, w.last);
                if (singular !== w.sing) report_mismatch("singular", singular, w.sing);
                if (w.sing && w.index == 0) singular_seen++;
                if (!w.sing && (w.value == VMAX || w.value == VMIN)) saturated_seen++;
            end
            beats_seen++;
        end
    end

    // Receiver stalls at random, except during calm stretches
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    task automatic send_element(input logic signed [DW-1:0] v);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        while (inverse_queue.size() != 0) @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] rnd_elem(input int shift);
        return $signed($urandom()) >>> shift;
    endfunction

    initial begin
        int                   kind;
        int                   sh;
        logic signed [DW-1:0] m [16];
        inv_beat_t            t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        element_value = '0;
        out_ready = 1'b0;
        fill_pos = '0;
        predict_on = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        beats_seen = 0;
        singular_seen = 0;
        saturated_seen = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: diagonal of extremes; inverse read off directly,
        // 2^32/1 and 2^32/-1 saturate high and low
        directed_rows = '{VMAX, 0, 0, 0,  0, VMIN, 0, 0,  0, 0, 1, 0,  0, 0, 0, -1};
        for (int k = 0; k < 16; k++) begin
            t.index = k[3:0];
            t.last  = (k == 15);
            t.sing  = 1'b0;
            case (k)
                0:       t.value = 2;
                5:       t.value = -2;
                10:      t.value = VMAX;
                15:      t.value = VMIN;
                default: t.value = 0;
            endcase
            inverse_queue.push_back(t);
        end
        for (int k = 0; k < 16; k++) send_element(directed_rows[k]);
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        predict_on = 1'b1;

        // Random matrices of several shapes
        for (int n = 0; n < RANDOM_MATRICES; n++) begin
            calm = (n >= 8 && n < 11);
            kind = $urandom_range(0, 9);
            sh = $urandom_range(8, 20);
            for (int k = 0; k < 16; k++) begin
                case (kind)
                    6, 7:    m[k] = (k / 4 == k % 4) ? 32'sh10000 + rnd_elem(sh + 4)
                                                     : rnd_elem(sh + 6);
                    8:       m[k] = $signed($urandom());
                    9:       m[k] = (k < 4) ? rnd_elem(sh) : 0;
                    default: m[k] = rnd_elem(sh);
                endcase
            end
            // Repeated row makes the matrix singular
            if (kind == 5) for (int c = 0; c < 4; c++) m[12 + c] = m[4 + c];
            for (int k = 0; k < 16; k++) send_element(m[k]);
            // Sender hold-off until every result is back
            if (n == 4) begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait_drained();
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b0;
        wait_drained();
        repeat (1000) @(posedge clk);

        $display("Run: %0d inverse beats checked over %0d matrices", beats_seen,
                 RANDOM_MATRICES + 1);
        $display("Singular matrices %0d, saturated elements %0d", singular_seen,
                 saturated_seen);
        if (mismatches == 0 && inverse_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
design/matinv_pkg.sv
design/matinv_div.sv
design/matrix4x4_inverse_top.sv
verif/tb_matrix4x4_inverse_top.sv
